### rtl/ort_pkg.sv
// Shared types and constants for the ordered record table.
`timescale 1ns / 1ps

package ort_pkg;

    // Fixed field widths of the command and result transactions
    localparam int KIND_W     = 3;
    localparam int POS_W      = 7;
    localparam int FIELD_REC_W = 32;
    localparam int STATUS_W   = 2;
    localparam int CNT_OUT_W  = 7;
    localparam int CAP_W      = 7;

    // Default sizing and register reset
    localparam int DEPTH_DEF     = 64;
    localparam int REC_WIDTH_DEF = 32;
    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    // Command kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_READ   = 3'd0,
        KIND_APPEND = 3'd1,
        KIND_INSERT = 3'd2,
        KIND_UPDATE = 3'd3,
        KIND_DELETE = 3'd4,
        KIND_CLEAR  = 3'd5
    } t_kind;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_RANGE = 2'd1,
        STATUS_FULL  = 2'd2
    } t_status;

    // Operation broadcast to every cell of the chain
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_WRITE,
        CELL_INSERT,
        CELL_DELETE,
        CELL_CAPTURE,
        CELL_SHIFT
    } t_cell_op;

    // Command transaction
    typedef struct packed {
        logic [KIND_W-1:0]      kind;
        logic [POS_W-1:0]       position;
        logic [FIELD_REC_W-1:0] record_in;
    } t_cmd;

    // Result transaction
    typedef struct packed {
        logic [STATUS_W-1:0]    status;
        logic [FIELD_REC_W-1:0] record_out;
        logic [CNT_OUT_W-1:0]   record_count;
    } t_result;

endpackage

### rtl/ordered_record_table_core.sv
// Ordered record table: command sequencer over a chain of record cells.
// A non-read or out-of-range command is executed in EXEC, which strobes its result;
// an in-range read captures the record there, and the read-out chain then moves it
// one cell per cycle toward cell 0, where the READ state strobes it.
// A new command is accepted in the cycle the previous result is strobed.
// Reset empties the table and loads capacity with 64; stored words are not cleared.
`timescale 1ns / 1ps

module ordered_record_table_core
    import ort_pkg::*;
#(
    parameter int DEPTH     = DEPTH_DEF,
    parameter int REC_WIDTH = REC_WIDTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    output logic             o_busy,
    input  t_cmd             i_cmd,
    output logic             o_done,
    output t_result          o_result,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CAP_W-1:0] i_cfg_data
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > POS_W) ? ((CNT_W > CAP_W) ? CNT_W : CAP_W)
                                           : ((POS_W > CAP_W) ? POS_W : CAP_W);
    localparam logic [CMP_W-1:0] DEPTH_CMP = CMP_W'(DEPTH);
    localparam logic [CMP_W-1:0] ONE_CMP   = CMP_W'(1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_READ
    } t_state;

    t_state             r_state;
    t_cmd               r_cmd;
    logic [CNT_W-1:0]   r_count;
    logic [CAP_W-1:0]   r_cap;
    logic [IDX_W-1:0]   r_shift;
    logic               r_done;
    t_result            r_result;

    // Cell chain wiring
    logic [REC_WIDTH-1:0] data_chain [DEPTH];
    logic [REC_WIDTH-1:0] rd_chain   [DEPTH];

    // Decoded command
    t_cell_op             cell_op;
    logic [IDX_W-1:0]     cell_idx;
    logic [REC_WIDTH-1:0] cell_rec;
    t_status              exec_status;
    logic [CNT_W-1:0]     n_count;
    logic                 go_read;
    logic                 accept;

    logic [CMP_W-1:0] pos_e;
    logic [CMP_W-1:0] cnt_e;
    logic [CMP_W-1:0] cap_e;
    logic [CMP_W-1:0] lim_e;
    logic             pos_ok;
    logic             full;
    logic [IDX_W-1:0] pos_idx;
    logic [IDX_W-1:0] cnt_idx;

    assign accept      = i_start && (r_state == ST_IDLE);
    assign o_busy      = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_done      = r_done;
    assign o_result    = r_result;

    // Range and capacity checks
    assign pos_e   = CMP_W'(r_cmd.position);
    assign cnt_e   = CMP_W'(r_count);
    assign cap_e   = CMP_W'(r_cap);
    assign lim_e   = (cap_e > DEPTH_CMP) ? DEPTH_CMP : cap_e;
    assign pos_ok  = (pos_e >= ONE_CMP) && (pos_e <= cnt_e);
    assign full    = (cnt_e >= lim_e);
    assign pos_idx = IDX_W'(pos_e - ONE_CMP);
    assign cnt_idx = IDX_W'(r_count);
    assign cell_rec = REC_WIDTH'(r_cmd.record_in);

    // Decode the held command into a cell operation
    always_comb begin
        cell_op     = CELL_HOLD;
        cell_idx    = pos_idx;
        exec_status = STATUS_OK;
        n_count     = r_count;
        go_read     = 1'b0;
        if (r_state == ST_READ) begin
            if (r_shift != '0) begin
                cell_op = CELL_SHIFT;
            end
        end else if (r_state == ST_EXEC) begin
            case (r_cmd.kind)
                KIND_READ: begin
                    if (pos_ok) begin
                        cell_op = CELL_CAPTURE;
                        go_read = 1'b1;
                    end else begin
                        exec_status = STATUS_RANGE;
                    end
                end
                KIND_APPEND: begin
                    if (full) begin
                        exec_status = STATUS_FULL;
                    end else begin
                        cell_op  = CELL_WRITE;
                        cell_idx = cnt_idx;
                        n_count  = r_count + CNT_W'(1);
                    end
                end
                KIND_INSERT: begin
                    if (full) begin
                        exec_status = STATUS_FULL;
                    end else if (r_count == '0) begin
                        if (pos_e == ONE_CMP) begin
                            cell_op  = CELL_WRITE;
                            cell_idx = '0;
                            n_count  = CNT_W'(1);
                        end else begin
                            exec_status = STATUS_RANGE;
                        end
                    end else if (!pos_ok) begin
                        exec_status = STATUS_RANGE;
                    end else begin
                        cell_op = CELL_INSERT;
                        n_count = r_count + CNT_W'(1);
                    end
                end
                KIND_UPDATE: begin
                    if (pos_ok) begin
                        cell_op = CELL_WRITE;
                    end else begin
                        exec_status = STATUS_RANGE;
                    end
                end
                KIND_DELETE: begin
                    if (pos_ok) begin
                        cell_op = CELL_DELETE;
                        n_count = r_count - CNT_W'(1);
                    end else begin
                        exec_status = STATUS_RANGE;
                    end
                end
                KIND_CLEAR: begin
                    n_count = '0;
                end
                default: begin
                    exec_status = STATUS_RANGE;
                end
            endcase
        end
    end

    // Sequence commands and hold the registered result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_cap   <= CAP_RESET;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_cfg_valid && o_cfg_ready) begin
                r_cap <= i_cfg_data;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_cmd   <= i_cmd;
                        r_state <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    r_count <= n_count;
                    if (go_read) begin
                        r_shift <= pos_idx;
                        r_state <= ST_READ;
                    end else begin
                        r_result.status       <= exec_status;
                        r_result.record_out   <= '0;
                        r_result.record_count <= CNT_OUT_W'(n_count);
                        r_done                <= 1'b1;
                        r_state               <= ST_IDLE;
                    end
                end
                ST_READ: begin
                    if (r_shift == '0) begin
                        r_result.status       <= STATUS_OK;
                        r_result.record_out   <= FIELD_REC_W'(rd_chain[0]);
                        r_result.record_count <= CNT_OUT_W'(r_count);
                        r_done                <= 1'b1;
                        r_state               <= ST_IDLE;
                    end else begin
                        r_shift <= r_shift - IDX_W'(1);
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Build the cell chain
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [REC_WIDTH-1:0] left_data;
        logic [REC_WIDTH-1:0] right_data;
        logic [REC_WIDTH-1:0] right_rd;

        if (g == 0) begin : g_first
            assign left_data = '0;
        end else begin : g_inner_left
            assign left_data = data_chain[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign right_data = '0;
            assign right_rd   = '0;
        end else begin : g_inner_right
            assign right_data = data_chain[g+1];
            assign right_rd   = rd_chain[g+1];
        end

        ort_cell #(
            .INDEX     (g),
            .IDX_W     (IDX_W),
            .REC_WIDTH (REC_WIDTH)
        ) u_cell (
            .i_clk        (i_clk),
            .i_op         (cell_op),
            .i_idx        (cell_idx),
            .i_rec        (cell_rec),
            .i_left_data  (left_data),
            .i_right_data (right_data),
            .i_right_rd   (right_rd),
            .o_data       (data_chain[g]),
            .o_rd         (rd_chain[g])
        );
    end

endmodule

### rtl/ort_cell.sv
// One storage cell of the record chain with its read-out shift stage.
`timescale 1ns / 1ps

module ort_cell
    import ort_pkg::*;
#(
    parameter int INDEX     = 0,
    parameter int IDX_W     = 6,
    parameter int REC_WIDTH = REC_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  t_cell_op             i_op,
    input  logic [IDX_W-1:0]     i_idx,
    input  logic [REC_WIDTH-1:0] i_rec,
    input  logic [REC_WIDTH-1:0] i_left_data,
    input  logic [REC_WIDTH-1:0] i_right_data,
    input  logic [REC_WIDTH-1:0] i_right_rd,
    output logic [REC_WIDTH-1:0] o_data,
    output logic [REC_WIDTH-1:0] o_rd
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

    logic [REC_WIDTH-1:0] r_data;
    logic [REC_WIDTH-1:0] r_rd;
    logic                 at_idx;
    logic                 above_idx;

    assign at_idx    = (i_idx == MY_IDX);
    assign above_idx = (MY_IDX > i_idx);

    // Update the stored record and the read-out stage
    always_ff @(posedge i_clk) begin
        case (i_op)
            CELL_WRITE: begin
                if (at_idx) begin
                    r_data <= i_rec;
                end
            end
            CELL_INSERT: begin
                if (at_idx) begin
                    r_data <= i_rec;
                end else if (above_idx) begin
                    r_data <= i_left_data;
                end
            end
            CELL_DELETE: begin
                if (at_idx || above_idx) begin
                    r_data <= i_right_data;
                end
            end
            CELL_CAPTURE: begin
                r_rd <= at_idx ? r_data : '0;
            end
            CELL_SHIFT: begin
                r_rd <= i_right_rd;
            end
            default: begin
            end
        endcase
    end

    assign o_data = r_data;
    assign o_rd   = r_rd;

endmodule

### sim/ordered_record_table_core_test.sv
// Self-checking testbench for the ordered record table core.
`timescale 1ns / 1ps

module ordered_record_table_core_test
    import ort_pkg::*;
();

    // Command kinds the block must reject
    localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd6;
    localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;
    localparam logic [POS_W-1:0]  POS_MAX       = '1;
    localparam logic [CAP_W-1:0]  CAP_MAX       = '1;
    localparam int ITEMS_PER_STAGE = 190;
    localparam int STAGES          = 9;
    // Slowest transaction is a read of the last record
    localparam int STALL_LIMIT     = 2000;

    // Mirror of the list contents; predicts one result per accepted command
    class record_list_board;
        logic [FIELD_REC_W-1:0] words[DEPTH_DEF];
        int unsigned held;
        int unsigned capacity;
        t_result awaited[$];
        int unsigned errors;

        function new();
            held = 0;
            capacity = 32'(CAP_RESET);
            errors = 0;
        endfunction

        function void set_capacity(logic [CAP_W-1:0] value);
            capacity = 32'(value);
        endfunction

        function int unsigned limit();
            return (capacity > DEPTH_DEF) ? DEPTH_DEF : capacity;
        endfunction

        function bit live(int unsigned pos);
            return pos >= 1 && pos <= held;
        endfunction

        function void note_command(t_cmd cmd);
            t_result want;
            int unsigned pos;
            int unsigned i;
            want.status = STATUS_OK;
            want.record_out = '0;
            pos = 32'(cmd.position);
            case (cmd.kind)
                KIND_READ: begin
                    if (live(pos)) want.record_out = words[pos-1];
                    else want.status = STATUS_RANGE;
                end
                KIND_APPEND: begin
                    if (held >= limit()) begin
                        want.status = STATUS_FULL;
                    end else begin
                        words[held] = cmd.record_in;
                        held++;
                    end
                end
                KIND_INSERT: begin
                    if (held >= limit()) begin
                        want.status = STATUS_FULL;
                    end else if (held == 0) begin
                        // empty list takes position 1 only
                        if (pos == 1) begin
                            words[0] = cmd.record_in;
                            held = 1;
                        end else begin
                            want.status = STATUS_RANGE;
                        end
                    end else if (!live(pos)) begin
                        want.status = STATUS_RANGE;
                    end else begin
                        // open a slot at pos, moving later records up
                        for (i = held; i > pos - 1; i--) words[i] = words[i-1];
                        words[pos-1] = cmd.record_in;
                        held++;
                    end
                end
                KIND_UPDATE: begin
                    if (live(pos)) words[pos-1] = cmd.record_in;
                    else want.status = STATUS_RANGE;
                end
                KIND_DELETE: begin
                    if (live(pos)) begin
                        // close the gap, moving later records down
                        for (i = pos - 1; i + 1 < held; i++) words[i] = words[i+1];
                        held--;
                    end else begin
                        want.status = STATUS_RANGE;
                    end
                end
                KIND_CLEAR: held = 0;
                default: want.status = STATUS_RANGE;
            endcase
            want.record_count = CNT_OUT_W'(held);
            awaited.push_back(want);
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (awaited.size() == 0) begin
                $error("result strobed with no command pending");
                errors++;
                return;
            end
            want = awaited.pop_front();
            if (got.status !== want.status) begin
                $error("status: expected %0d, actual %0d", want.status, got.status);
                errors++;
            end
            if (got.record_out !== want.record_out) begin
                $error("record_out: expected %h, actual %h", want.record_out, got.record_out);
                errors++;
            end
            if (got.record_count !== want.record_count) begin
                $error("record_count: expected %0d, actual %0d",
                       want.record_count, got.record_count);
                errors++;
            end
        endfunction
    endclass

    logic             i_clk;
    logic             i_rst_n;
    logic             i_start;
    logic             o_busy;
    t_cmd             i_cmd;
    logic             o_done;
    t_result          o_result;
    logic             i_cfg_valid;
    logic             o_cfg_ready;
    logic [CAP_W-1:0] i_cfg_data;

    record_list_board board;
    int unsigned cmds_taken;
    int unsigned cfg_taken;
    int unsigned stall_cycles;
    int unsigned idle_pct;
    bit          moved;

    ordered_record_table_core DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_start),
        .o_busy     (o_busy),
        .i_cmd      (i_cmd),
        .o_done     (o_done),
        .o_result   (o_result),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Observe every handshake at the rising edge; watch for a hung block
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            moved = 1'b0;
            if (o_done) begin
                board.check_result(o_result);
                moved = 1'b1;
            end
            if (i_start && !o_busy) begin
                board.note_command(i_cmd);
                cmds_taken++;
                moved = 1'b1;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                board.set_capacity(i_cfg_data);
                cfg_taken++;
                moved = 1'b1;
            end
            if (moved) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
                if (stall_cycles >= STALL_LIMIT) begin
                    $display("tb: failure");
                    $finish;
                end
            end
        end
    end

    // Issue one command and hold it until the block takes it
    task automatic send_cmd(input logic [KIND_W-1:0] kind, input logic [POS_W-1:0] pos,
                            input logic [FIELD_REC_W-1:0] rec);
        int unsigned seen;
        seen = cmds_taken;
        i_cmd.kind = kind;
        i_cmd.position = pos;
        i_cmd.record_in = rec;
        i_start = 1'b1;
        do @(negedge i_clk); while (cmds_taken == seen);
        if ($urandom_range(0, 99) < idle_pct) begin
            i_start = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
    endtask

    // Mostly well-formed commands on live positions, with some noise
    task automatic send_random();
        int unsigned pick;
        int unsigned pos;
        int unsigned n;
        logic [KIND_W-1:0] kind;
        n = board.held;
        pick = $urandom_range(0, 999);
        if (pick < 300) kind = KIND_APPEND;
        else if (pick < 520) kind = KIND_INSERT;
        else if (pick < 700) kind = KIND_READ;
        else if (pick < 800) kind = KIND_UPDATE;
        else if (pick < 930) kind = KIND_DELETE;
        else if (pick < 935) kind = KIND_CLEAR;
        else if (pick < 960) kind = $urandom_range(0, 1) ? KIND_SPARE_LO : KIND_SPARE_HI;
        else kind = KIND_W'($urandom_range(0, 7));
        if ($urandom_range(0, 99) < 85) pos = (n == 0) ? 1 : $urandom_range(1, n);
        else pos = $urandom_range(0, 32'(POS_MAX));
        send_cmd(kind, POS_W'(pos), $urandom());
    endtask

    // Drop start and wait for every pending result
    task automatic drain();
        i_start = 1'b0;
        while (board.awaited.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // Write the capacity register while the block is idle
    task automatic write_capacity(input logic [CAP_W-1:0] value);
        int unsigned seen;
        drain();
        seen = cfg_taken;
        i_cfg_data = value;
        i_cfg_valid = 1'b1;
        do @(negedge i_clk); while (cfg_taken == seen);
        i_cfg_valid = 1'b0;
    endtask

    // Stimulus
    initial begin
        logic [CAP_W-1:0] cap_plan[STAGES];
        int s;
        cap_plan = '{CAP_MAX, 7'd5, CAP_RESET, 7'd1, 7'd0, 7'd33, CAP_MAX, 7'd12, CAP_RESET};
        board = new();
        cmds_taken = 0;
        cfg_taken = 0;
        stall_cycles = 0;
        moved = 1'b0;
        idle_pct = 28;
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_cmd = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Empty list: reads, deletes and inserts off position 1 are rejected
        send_cmd(KIND_READ, 7'd1, '0);
        send_cmd(KIND_DELETE, 7'd1, '0);
        send_cmd(KIND_INSERT, 7'd2, $urandom());
        send_cmd(KIND_INSERT, 7'd1, '1);
        send_cmd(KIND_APPEND, 7'd0, '0);
        send_cmd(KIND_APPEND, POS_MAX, 32'hA5A5_5A5A);
        send_cmd(KIND_INSERT, 7'd0, $urandom());
        send_cmd(KIND_INSERT, 7'd2, $urandom());
        send_cmd(KIND_INSERT, 7'd4, $urandom());
        send_cmd(KIND_READ, 7'd0, '0);
        send_cmd(KIND_READ, 7'd1, '0);
        send_cmd(KIND_READ, 7'd5, '1);
        send_cmd(KIND_READ, 7'd6, '0);
        send_cmd(KIND_UPDATE, 7'd5, $urandom());
        send_cmd(KIND_UPDATE, 7'd6, $urandom());
        send_cmd(KIND_UPDATE, 7'd0, $urandom());
        send_cmd(KIND_DELETE, 7'd1, '0);
        send_cmd(KIND_DELETE, 7'd4, '0);
        send_cmd(KIND_DELETE, POS_MAX, '0);
        send_cmd(KIND_READ, 7'd64, '0);
        send_cmd(KIND_SPARE_LO, 7'd1, $urandom());
        send_cmd(KIND_SPARE_HI, 7'd2, $urandom());
        send_cmd(KIND_CLEAR, 7'd3, $urandom());
        send_cmd(KIND_READ, 7'd1, '0);

        // Zero capacity: full takes precedence even on an empty list
        write_capacity(7'd0);
        send_cmd(KIND_APPEND, 7'd0, $urandom());
        send_cmd(KIND_INSERT, 7'd1, $urandom());
        // Fill to a small capacity, then lower it below the count
        write_capacity(7'd2);
        send_cmd(KIND_APPEND, 7'd0, $urandom());
        send_cmd(KIND_APPEND, 7'd0, $urandom());
        send_cmd(KIND_APPEND, 7'd0, $urandom());
        write_capacity(7'd1);
        send_cmd(KIND_INSERT, 7'd1, $urandom());
        send_cmd(KIND_READ, 7'd2, '0);

        // Random stages: sender idles 28%, then 55%, then never
        for (s = 0; s < STAGES; s++) begin
            write_capacity(cap_plan[s]);
            idle_pct = (s < 3) ? 28 : (s < 6) ? 55 : 0;
            repeat (ITEMS_PER_STAGE) send_random();
        end

        drain();
        repeat (DEPTH_DEF + 8) @(negedge i_clk);
        if (board.errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

### ordered_record_table_core.f
rtl/ort_pkg.sv
rtl/ort_cell.sv
rtl/ordered_record_table_core.sv
sim/ordered_record_table_core_test.sv
